### sv/hl7u_pkg.sv
// shared types and constants for the hl7 extended ascii unescape unit
package hl7u_pkg;

	localparam int HDR_LEN  = 9;
	localparam int PEND_MAX = 4;
	localparam int CNT_W    = 4;

	// burst of result bytes produced by one input byte
	typedef struct packed {
		logic [HDR_LEN-1:0][7:0] bytes;
		logic [CNT_W-1:0]        count;
		logic                    last;
	} hl7u_burst_t;

endpackage

### sv/hl7u_core.sv
// message state and decode logic: header check, escape sequence matching
module hl7u_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  logic [7:0]          item_byte,
	input  logic                item_last,
	output hl7u_pkg::hl7u_burst_t burst
);
	import hl7u_pkg::*;

	localparam logic [7:0] CH_M = 8'h4D;
	localparam logic [7:0] CH_S = 8'h53;
	localparam logic [7:0] CH_H = 8'h48;
	localparam logic [7:0] CH_X_UP = 8'h58;
	localparam logic [7:0] CH_X_LO = 8'h78;
	localparam int ESC_POS = 6;

	typedef enum logic [1:0] {PH_SKIP, PH_HDR, PH_DEC, PH_RAW} phase_t;

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'h09 || c == 8'h0A || c == 8'h0B || c == 8'h0C ||
			c == 8'h0D || c == 8'h20;
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic is_punct(input logic [7:0] c);
		return c >= 8'h21 && c <= 8'h7E && !is_alnum(c);
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
			(c >= 8'h61 && c <= 8'h66);
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] v;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c - 8'h30;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = c - 8'h37;
		end else begin
			v = c - 8'h57;
		end
		return v[3:0];
	endfunction

	phase_t      phase_q, phase_d;
	logic [7:0]  hdr_q  [HDR_LEN];
	logic [7:0]  pend_q [PEND_MAX];
	logic [3:0]  hcnt_q, hcnt_d;
	logic [2:0]  pcnt_q, pcnt_d;
	logic [7:0]  esc_q, esc_d;
	logic        hdr_we, pend_we;
	logic [1:0]  pend_wa;
	logic [7:0]  hdr_new [HDR_LEN];
	logic        hdr_ok;
	logic        seq_ok;
	logic        hold_esc;
	logic [7:0]  value;

	// header as it stands with the current byte placed at the fill position
	always_comb begin
		for (int i = 0; i < HDR_LEN; i++) begin
			hdr_new[i] = (4'(i) < hcnt_q) ? hdr_q[i] : item_byte;
		end
	end

	always_comb begin
		hdr_ok = hdr_new[0] == CH_M && hdr_new[1] == CH_S && hdr_new[2] == CH_H &&
			hdr_new[3] == hdr_new[HDR_LEN-1];
		for (int i = 0; i < HDR_LEN; i++) begin
			if (hdr_new[i] == 8'h00) begin
				hdr_ok = 1'b0;
			end
		end
		for (int i = 5; i < HDR_LEN; i++) begin
			if (!is_punct(hdr_new[i])) begin
				hdr_ok = 1'b0;
			end
		end
		for (int i = 4; i < HDR_LEN; i++) begin
			for (int j = i + 1; j < HDR_LEN; j++) begin
				if (hdr_new[i] == hdr_new[j]) begin
					hdr_ok = 1'b0;
				end
			end
		end
	end

	assign value    = {hex_val(pend_q[2]), hex_val(pend_q[3])};
	assign hold_esc = item_byte == esc_q && !item_last;

	always_comb begin
		case (pcnt_q) inside
			3'd1:          seq_ok = item_byte == CH_X_UP || item_byte == CH_X_LO;
			[3'd2:3'd3]:   seq_ok = is_hex(item_byte);
			3'd4:          seq_ok = item_byte == esc_q && value[7];
			default:       seq_ok = 1'b0;
		endcase
	end

	always_comb begin
		phase_d = phase_q;
		hcnt_d  = hcnt_q;
		pcnt_d  = pcnt_q;
		esc_d   = esc_q;
		hdr_we  = 1'b0;
		pend_we = 1'b0;
		pend_wa = pcnt_q[1:0];
		burst.last  = item_last;
		burst.count = '0;
		for (int i = 0; i < HDR_LEN; i++) begin
			burst.bytes[i] = item_byte;
		end
		unique case (phase_q)
			PH_SKIP: begin
				if (is_space(item_byte)) begin
					burst.count = CNT_W'(1);
				end else begin
					hdr_we  = 1'b1;
					hcnt_d  = 4'd1;
					phase_d = PH_HDR;
					if (item_last) begin
						burst.count = CNT_W'(1);
					end
				end
			end
			PH_HDR: begin
				hdr_we = 1'b1;
				hcnt_d = hcnt_q + 4'd1;
				for (int i = 0; i < HDR_LEN; i++) begin
					burst.bytes[i] = hdr_new[i];
				end
				if (hcnt_q == 4'(HDR_LEN - 1)) begin
					burst.count = CNT_W'(HDR_LEN);
					hcnt_d = '0;
					if (hdr_ok) begin
						esc_d   = hdr_new[ESC_POS];
						phase_d = PH_DEC;
					end else begin
						phase_d = PH_RAW;
					end
				end else if (item_last) begin
					burst.count = hcnt_q + 4'd1;
				end
			end
			PH_DEC: begin
				for (int i = 0; i < PEND_MAX; i++) begin
					burst.bytes[i] = (3'(i) < pcnt_q) ? pend_q[i] : item_byte;
				end
				if (pcnt_q == 3'd0) begin
					if (hold_esc) begin
						pend_we = 1'b1;
						pend_wa = 2'd0;
						pcnt_d  = 3'd1;
					end else begin
						burst.count = CNT_W'(1);
					end
				end else if (seq_ok && pcnt_q == 3'(PEND_MAX)) begin
					burst.count    = CNT_W'(1);
					burst.bytes[0] = value;
					pcnt_d = 3'd0;
				end else if (seq_ok) begin
					if (item_last) begin
						burst.count = CNT_W'(pcnt_q) + CNT_W'(1);
						pcnt_d = 3'd0;
					end else begin
						pend_we = 1'b1;
						pcnt_d  = pcnt_q + 3'd1;
					end
				end else begin
					// broken sequence: held bytes go out raw, current byte rescanned
					if (hold_esc) begin
						pend_we = 1'b1;
						pend_wa = 2'd0;
						pcnt_d  = 3'd1;
						burst.count = CNT_W'(pcnt_q);
					end else begin
						pcnt_d = 3'd0;
						burst.count = CNT_W'(pcnt_q) + CNT_W'(1);
					end
				end
			end
			PH_RAW: begin
				burst.count = CNT_W'(1);
			end
			default: begin
				phase_d = PH_SKIP;
			end
		endcase
		if (item_last) begin
			phase_d = PH_SKIP;
			hcnt_d  = '0;
			pcnt_d  = '0;
			esc_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIP;
			hcnt_q  <= '0;
			pcnt_q  <= '0;
			esc_q   <= '0;
		end else if (go) begin
			phase_q <= phase_d;
			hcnt_q  <= hcnt_d;
			pcnt_q  <= pcnt_d;
			esc_q   <= esc_d;
		end
	end

	always_ff @(posedge clk) begin
		if (go && hdr_we) begin
			hdr_q[hcnt_q] <= item_byte;
		end
		if (go && pend_we) begin
			pend_q[pend_wa] <= item_byte;
		end
	end

endmodule

### sv/hl7u_burst.sv
// result register: holds one output burst, drains one per cycle unless stalled
module hl7u_burst (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  hl7u_pkg::hl7u_burst_t fill,
	input  logic                  out_stall,
	output logic                  free,
	output logic                  out_valid,
	output logic [7:0]            out_byte,
	output logic                  out_last
);
	import hl7u_pkg::*;

	logic [HDR_LEN-1:0][7:0] data_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    last_q;
	logic                    pop;

	assign out_valid = cnt_q != '0;
	assign pop       = out_valid && !out_stall;
	// room for a new burst once the final byte of this one leaves
	assign free      = cnt_q == '0 || (cnt_q == CNT_W'(1) && !out_stall);
	assign out_byte  = data_q[0];
	assign out_last  = last_q && cnt_q == CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			last_q <= 1'b0;
		end else if (load) begin
			cnt_q  <= fill.count;
			last_q <= fill.last;
		end else if (pop) begin
			cnt_q  <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= fill.bytes;
		end else if (pop) begin
			data_q <= {8'h00, data_q[HDR_LEN-1:1]};
		end
	end

endmodule

### sv/hl7_extended_ascii_unescape_unit.sv
// hl7 extended ascii unescape unit: top level
// Usage: message bytes enter on in_valid/in_stall with in_byte and in_last;
// decoded bytes leave on out_valid/out_stall with out_byte and out_last.
// A transaction is taken on a rising edge with valid high and stall low.
// Each input byte is registered, then decoded combinationally into a burst of
// zero to nine output bytes that loads the result register.
// One input byte is taken per cycle while each yields at most one output byte
// and out_stall is low; a burst of n bytes (header release, broken escape,
// end-of-message flush) leaves one byte per output transaction, and in_stall
// rises while it drains if the input register holds the next byte.
// out_last marks the final output byte of a message; after the byte with
// in_last the message state returns to its reset values.
// Reset (arst_n low) clears the input valid flag, the burst counter and the
// decode state; no output is valid until bytes arrive.
// A held out_stall keeps the current output byte in place and, once the
// input register is full, pushes back with in_stall.
module hl7_extended_ascii_unescape_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       out_last
);
	import hl7u_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        free;
	logic        go;
	logic        accept;
	hl7u_burst_t burst;

	assign go       = valid_s1 && free;
	assign in_stall = valid_s1 && !free;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	hl7u_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.item_byte (byte_s1),
		.item_last (last_s1),
		.burst     (burst)
	);

	hl7u_burst u_burst (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (go),
		.fill      (burst),
		.out_stall (out_stall),
		.free      (free),
		.out_valid (out_valid),
		.out_byte  (out_byte),
		.out_last  (out_last)
	);

endmodule

### sv/hl7u_checker.sv
// port-level checks for the hl7 extended ascii unescape unit
module hl7u_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       out_last
);

	// a stalled output transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
		else $error("output changed while stalled");

	// input back-pressure only comes from a burst still draining
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no output pending");

	// when the output moves yet the input is held, more of the burst remains
	a_stall_not_final: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall && !out_stall |-> !out_last)
		else $error("input stalled behind the final byte of a burst");

	// input stall only starts right after an input transaction
	a_stall_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid && !in_stall))
		else $error("input stalled with no transaction waiting");

endmodule

bind hl7_extended_ascii_unescape_unit hl7u_checker u_hl7u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_byte  (out_byte),
	.out_last  (out_last)
);
